[rtl/core/sacta_pkg.sv]
// Package for the set-associative cache tag array: sizes, request and response
// types, the stored line format and the controller states. No dependencies.
`default_nettype none
package sacta_pkg;
    localparam int SETS      = 256;
    localparam int WAYS      = 16;
    localparam int AW        = 48;
    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int CNT_W     = 32;
    localparam int LFSR_W    = 32;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_WAYS = 2'd1;
    localparam logic [1:0] CFG_SETB = 2'd2;

    localparam logic REQ_LOOKUP  = 1'b0;
    localparam logic REQ_INSTALL = 1'b1;
    localparam logic MODE_LRU    = 1'b0;
    localparam logic MODE_RANDOM = 1'b1;

    typedef struct packed {
        logic          req_type;
        logic [47:0]   line_addr;
        logic          wr_req;
        logic [1:0]    core_num;
        logic [47:0]   time_stamp;
    } t_req;

    typedef struct packed {
        logic          hit;
        logic          victim_valid;
        logic          victim_dirty;
        logic [47:0]   victim_line_addr;
        logic [1:0]    victim_core;
        logic [31:0]   read_accesses;
        logic [31:0]   write_accesses;
        logic [31:0]   read_misses;
        logic [31:0]   write_misses;
        logic [31:0]   dirty_evictions;
    } t_rsp;

    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [AW-1:0] tag;
        logic [1:0]    owner;
        logic [AW-1:0] last_use;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_WRITE
    } t_state;
endpackage
`default_nettype wire

[rtl/core/set_assoc_cache_tag_array.sv]
// Each request reads its set, then scans the configured ways (lookup or LRU install) or runs
// restoring remainder steps on the LFSR value (random install), then writes the row back.
// One request in flight; the set memory's single port and the per-way scan set the rate.
// Reset (synchronous, active low) clears per-set valid flags, so every set reads as
// empty at once; counters clear, the LFSR loads 1 and the registers take defaults.
// Depends on sacta_pkg.
`default_nettype none
module set_assoc_cache_tag_array (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire sacta_pkg::t_req i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output sacta_pkg::t_rsp      o_rsp,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_addr,
    input  wire logic [4:0]      i_cfg_data
);
    sacta_pkg::t_row  mem [sacta_pkg::SETS];
    sacta_pkg::t_row  r_rd;
    logic [sacta_pkg::SETS-1:0] r_set_vld;
    logic             r_row_vld;

    sacta_pkg::t_state r_state, n_state;
    sacta_pkg::t_req   r_req;
    sacta_pkg::t_rsp   r_rsp;
    logic              r_out_vld;

    logic        r_mode;
    logic [4:0]  r_ways_cfg;
    logic [3:0]  r_sb_cfg;
    logic [sacta_pkg::LFSR_W-1:0] r_lfsr;
    logic [sacta_pkg::CNT_W-1:0]  r_rd_acc, r_wr_acc, r_rd_miss, r_wr_miss, r_dirty_ev;

    logic [sacta_pkg::SET_W-1:0] r_set;
    logic [sacta_pkg::AW-1:0]    r_tag;
    logic [3:0]                  r_sb;
    logic [4:0]                  r_ways;
    logic [sacta_pkg::WAY_W-1:0] r_way, r_victim, r_found_way;
    logic                        r_found;
    logic [sacta_pkg::AW-1:0]    r_oldest;
    logic [sacta_pkg::LFSR_W-1:0] r_dividend;
    logic [4:0]                  r_rem, r_bit;

    logic [3:0]  sb_eff;
    logic [4:0]  ways_eff;
    logic [sacta_pkg::SET_W-1:0] set_in;
    logic [sacta_pkg::LFSR_W-1:0] lfsr_nx;
    logic        accept, mem_we, scan_last, out_free;
    sacta_pkg::t_row  row_eff, row_new;
    sacta_pkg::t_line cur, old_line;
    logic [sacta_pkg::WAY_W-1:0] wb_way;
    logic [5:0]  rem_try;
    logic [sacta_pkg::AW-1:0] vaddr;

    always_comb begin
        sb_eff   = (r_sb_cfg > 4'(sacta_pkg::SET_W)) ? 4'(sacta_pkg::SET_W) : r_sb_cfg;
        ways_eff = (r_ways_cfg == 5'd0) ? 5'd1 :
                   (r_ways_cfg > 5'(sacta_pkg::WAYS)) ? 5'(sacta_pkg::WAYS) : r_ways_cfg;
        set_in   = i_req.line_addr[sacta_pkg::SET_W-1:0]
                   & ~({sacta_pkg::SET_W{1'b1}} << sb_eff);
        lfsr_nx  = r_lfsr[0] ? ((r_lfsr >> 1) ^ sacta_pkg::LFSR_TAPS) : (r_lfsr >> 1);
    end

    assign o_req_ready = (r_state == sacta_pkg::S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_rsp;
    assign out_free    = !r_out_vld || i_rsp_ready;

    assign row_eff   = r_row_vld ? r_rd : '0;
    assign cur       = row_eff[r_way];
    assign scan_last = ({1'b0, r_way} == 5'(r_ways - 5'd1));
    assign rem_try   = {r_rem, r_dividend[r_bit]};

    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        case (r_state)
            sacta_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == sacta_pkg::REQ_INSTALL
                        && r_mode == sacta_pkg::MODE_RANDOM) begin
                        n_state = sacta_pkg::S_DIV;
                    end else begin
                        n_state = sacta_pkg::S_SCAN;
                    end
                end
            end
            sacta_pkg::S_SCAN: begin
                if (scan_last) n_state = sacta_pkg::S_WRITE;
            end
            sacta_pkg::S_DIV: begin
                if (r_bit == 5'd0) n_state = sacta_pkg::S_WRITE;
            end
            sacta_pkg::S_WRITE: begin
                if (out_free) begin
                    mem_we  = 1'b1;
                    n_state = sacta_pkg::S_IDLE;
                end
            end
            default: n_state = sacta_pkg::S_IDLE;
        endcase
    end

    // Write-back row: a hit refreshes the found way, an install refills the victim.
    always_comb begin
        row_new  = row_eff;
        wb_way   = (r_req.req_type == sacta_pkg::REQ_INSTALL) ? r_victim : r_found_way;
        old_line = row_eff[wb_way];
        if (r_req.req_type == sacta_pkg::REQ_INSTALL) begin
            row_new[wb_way].valid    = 1'b1;
            row_new[wb_way].dirty    = r_req.wr_req;
            row_new[wb_way].tag      = r_tag;
            row_new[wb_way].owner    = r_req.core_num;
            row_new[wb_way].last_use = r_req.time_stamp;
        end else if (r_found) begin
            row_new[wb_way].owner    = r_req.core_num;
            row_new[wb_way].last_use = r_req.time_stamp;
            row_new[wb_way].dirty    = old_line.dirty | r_req.wr_req;
        end
        vaddr = (old_line.tag << r_sb) | sacta_pkg::AW'(r_set);
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_rd <= mem[set_in];
        if (mem_we) mem[r_set] <= row_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sacta_pkg::S_IDLE;
            r_out_vld  <= 1'b0;
            r_set_vld  <= '0;
            r_mode     <= sacta_pkg::MODE_LRU;
            r_ways_cfg <= 5'd16;
            r_sb_cfg   <= 4'd8;
            r_lfsr     <= sacta_pkg::LFSR_SEED;
            r_rd_acc   <= '0;
            r_wr_acc   <= '0;
            r_rd_miss  <= '0;
            r_wr_miss  <= '0;
            r_dirty_ev <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    sacta_pkg::CFG_MODE: r_mode     <= i_cfg_data[0];
                    sacta_pkg::CFG_WAYS: r_ways_cfg <= i_cfg_data;
                    sacta_pkg::CFG_SETB: r_sb_cfg   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (!mem_we && i_rsp_ready) r_out_vld <= 1'b0;
            if (accept && i_req.req_type == sacta_pkg::REQ_INSTALL
                && r_mode == sacta_pkg::MODE_RANDOM) begin
                r_lfsr <= lfsr_nx;
            end
            if (mem_we) begin
                r_set_vld[r_set] <= 1'b1;
                r_out_vld        <= 1'b1;
                if (r_req.req_type == sacta_pkg::REQ_LOOKUP) begin
                    if (r_req.wr_req) begin
                        r_wr_acc <= r_wr_acc + 32'd1;
                        if (!r_found) r_wr_miss <= r_wr_miss + 32'd1;
                    end else begin
                        r_rd_acc <= r_rd_acc + 32'd1;
                        if (!r_found) r_rd_miss <= r_rd_miss + 32'd1;
                    end
                end else if (old_line.dirty) begin
                    r_dirty_ev <= r_dirty_ev + 32'd1;
                end
            end
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            sacta_pkg::S_IDLE: begin
                if (accept) begin
                    r_req       <= i_req;
                    r_set       <= set_in;
                    r_tag       <= i_req.line_addr >> sb_eff;
                    r_sb        <= sb_eff;
                    r_ways      <= ways_eff;
                    r_row_vld   <= r_set_vld[set_in];
                    r_way       <= '0;
                    r_victim    <= '0;
                    r_found     <= 1'b0;
                    r_found_way <= '0;
                    r_oldest    <= i_req.time_stamp;
                    r_dividend  <= lfsr_nx;
                    r_rem       <= '0;
                    r_bit       <= 5'd31;
                end
            end
            sacta_pkg::S_SCAN: begin
                if (r_req.req_type == sacta_pkg::REQ_LOOKUP) begin
                    if (!r_found && cur.valid && cur.tag == r_tag) begin
                        r_found     <= 1'b1;
                        r_found_way <= r_way;
                    end
                end else if (cur.last_use < r_oldest) begin
                    r_oldest <= cur.last_use;
                    r_victim <= r_way;
                end
                r_way <= r_way + sacta_pkg::WAY_W'(1);
            end
            sacta_pkg::S_DIV: begin
                // One restoring remainder step per cycle, most significant bit first.
                if (rem_try >= {1'b0, r_ways}) begin
                    r_rem <= 5'(rem_try - {1'b0, r_ways});
                    if (r_bit == 5'd0) r_victim <= 4'(rem_try - {1'b0, r_ways});
                end else begin
                    r_rem <= rem_try[4:0];
                    if (r_bit == 5'd0) r_victim <= rem_try[3:0];
                end
                r_bit <= r_bit - 5'd1;
            end
            sacta_pkg::S_WRITE: begin
                if (out_free) begin
                    r_rsp.hit <= (r_req.req_type == sacta_pkg::REQ_LOOKUP) && r_found;
                    if (r_req.req_type == sacta_pkg::REQ_INSTALL && old_line.valid) begin
                        r_rsp.victim_valid     <= 1'b1;
                        r_rsp.victim_dirty     <= old_line.dirty;
                        r_rsp.victim_line_addr <= vaddr;
                        r_rsp.victim_core      <= old_line.owner;
                    end else begin
                        r_rsp.victim_valid     <= 1'b0;
                        r_rsp.victim_dirty     <= 1'b0;
                        r_rsp.victim_line_addr <= '0;
                        r_rsp.victim_core      <= '0;
                    end
                    r_rsp.read_accesses  <= r_rd_acc  + 32'((r_req.req_type
                        == sacta_pkg::REQ_LOOKUP) && !r_req.wr_req);
                    r_rsp.write_accesses <= r_wr_acc  + 32'((r_req.req_type
                        == sacta_pkg::REQ_LOOKUP) && r_req.wr_req);
                    r_rsp.read_misses    <= r_rd_miss + 32'((r_req.req_type
                        == sacta_pkg::REQ_LOOKUP) && !r_req.wr_req && !r_found);
                    r_rsp.write_misses   <= r_wr_miss + 32'((r_req.req_type
                        == sacta_pkg::REQ_LOOKUP) && r_req.wr_req && !r_found);
                    r_rsp.dirty_evictions <= r_dirty_ev + 32'((r_req.req_type
                        == sacta_pkg::REQ_INSTALL) && old_line.dirty);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the set-associative cache tag array: lookups and installs with
// LRU and random replacement, checked against a local model. Depends on sacta_pkg.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_req_valid = 1'b0;
    logic            o_req_ready;
    sacta_pkg::t_req i_req = '0;
    logic            o_rsp_valid;
    logic            i_rsp_ready = 1'b0;
    sacta_pkg::t_rsp o_rsp;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [1:0]      i_cfg_addr = '0;
    logic [4:0]      i_cfg_data = '0;

    set_assoc_cache_tag_array i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Local copy of the tag store and registers.
    sacta_pkg::t_line cache_lines [sacta_pkg::SETS][sacta_pkg::WAYS];
    logic [31:0] lfsr_state;
    logic [31:0] cnt_rd, cnt_wr, cnt_rd_miss, cnt_wr_miss, cnt_dirty_ev;
    logic        mode_reg;
    logic [4:0]  ways_reg;
    logic [3:0]  setb_reg;

    sacta_pkg::t_rsp pending_rsp [$];
    int          errors = 0;
    int          cycles = 0;
    int          n_reqs = 0;
    int          n_rsps = 0;
    int          n_hits = 0;
    int          n_dirty_victims = 0;
    bit          idle_on = 1'b1;
    logic [47:0] now_ts = 48'd16;

    function automatic int eff_ways();
        if (ways_reg == 0) return 1;
        if (ways_reg > sacta_pkg::WAYS) return sacta_pkg::WAYS;
        return ways_reg;
    endfunction

    function automatic int eff_setb();
        return (setb_reg > sacta_pkg::SET_W) ? sacta_pkg::SET_W : setb_reg;
    endfunction

    function automatic void predict_access(sacta_pkg::t_req r);
        int              sb, nw, set_i, victim, found;
        logic [47:0]     tag, oldest;
        logic [63:0]     va;
        sacta_pkg::t_rsp e;
        sb = eff_setb();
        nw = eff_ways();
        set_i = int'(r.line_addr & ((48'd1 << sb) - 48'd1));
        tag = r.line_addr >> sb;
        e = '0;
        if (r.req_type == sacta_pkg::REQ_LOOKUP) begin
            found = -1;
            for (int w = 0; w < nw; w++)
                if (found < 0 && cache_lines[set_i][w].valid &&
                    cache_lines[set_i][w].tag == tag)
                    found = w;
            if (r.wr_req) cnt_wr++; else cnt_rd++;
            if (found < 0) begin
                if (r.wr_req) cnt_wr_miss++; else cnt_rd_miss++;
            end else begin
                e.hit = 1'b1;
                cache_lines[set_i][found].owner = r.core_num;
                cache_lines[set_i][found].last_use = r.time_stamp;
                if (r.wr_req) cache_lines[set_i][found].dirty = 1'b1;
            end
        end else begin
            victim = 0;
            if (mode_reg == sacta_pkg::MODE_LRU) begin
                oldest = r.time_stamp;
                for (int w = 0; w < nw; w++)
                    if (cache_lines[set_i][w].last_use < oldest) begin
                        oldest = cache_lines[set_i][w].last_use;
                        victim = w;
                    end
            end else begin
                lfsr_state = lfsr_state[0] ? ((lfsr_state >> 1) ^ sacta_pkg::LFSR_TAPS)
                                           : (lfsr_state >> 1);
                victim = int'(lfsr_state % nw);
            end
            if (cache_lines[set_i][victim].dirty) cnt_dirty_ev++;
            if (cache_lines[set_i][victim].valid) begin
                e.victim_valid = 1'b1;
                e.victim_dirty = cache_lines[set_i][victim].dirty;
                va = (64'(cache_lines[set_i][victim].tag) << sb) | 64'(set_i);
                e.victim_line_addr = va[47:0];
                e.victim_core = cache_lines[set_i][victim].owner;
            end
            cache_lines[set_i][victim].valid = 1'b1;
            cache_lines[set_i][victim].dirty = r.wr_req;
            cache_lines[set_i][victim].tag = tag;
            cache_lines[set_i][victim].owner = r.core_num;
            cache_lines[set_i][victim].last_use = r.time_stamp;
        end
        e.read_accesses = cnt_rd;
        e.write_accesses = cnt_wr;
        e.read_misses = cnt_rd_miss;
        e.write_misses = cnt_wr_miss;
        e.dirty_evictions = cnt_dirty_ev;
        pending_rsp.push_back(e);
    endfunction

    task automatic send_req(sacta_pkg::t_req r);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_req_ready);
        predict_access(r);
        n_reqs++;
    endtask

    task automatic wait_idle();
        i_req_valid <= 1'b0;
        while (pending_rsp.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            sacta_pkg::CFG_MODE: mode_reg = data[0];
            sacta_pkg::CFG_WAYS: ways_reg = data;
            sacta_pkg::CFG_SETB: setb_reg = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic mode, logic [4:0] ways, logic [4:0] setb);
        wait_idle();
        write_reg(sacta_pkg::CFG_MODE, {4'd0, mode});
        write_reg(sacta_pkg::CFG_WAYS, ways);
        write_reg(sacta_pkg::CFG_SETB, setb);
    endtask

    // Small tag and set pools keep conflicts and hits frequent; now and then a
    // fully random address or timestamp exercises every bit.
    function automatic sacta_pkg::t_req make_req(logic kind);
        sacta_pkg::t_req r;
        int              sb;
        logic [47:0]     tag, set_v;
        sb = eff_setb();
        r.req_type = kind;
        r.wr_req = 1'($urandom_range(0, 1));
        r.core_num = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0) begin
            r.line_addr = 48'({$urandom(), $urandom()});
        end else begin
            tag = 48'($urandom_range(0, 5));
            set_v = 48'($urandom_range(0, 3));
            r.line_addr = (tag << sb) | (set_v & ((48'd1 << sb) - 48'd1));
        end
        if ($urandom_range(0, 19) == 0) begin
            r.time_stamp = 48'({$urandom(), $urandom()});
        end else begin
            now_ts = now_ts + 48'($urandom_range(0, 3));
            r.time_stamp = now_ts;
        end
        return r;
    endfunction

    // Mostly lookups, each often followed by an install of the same line whether it hit or missed.
    task automatic run_traffic(int count);
        sacta_pkg::t_req r;
        for (int k = 0; k < count; k++) begin
            r = make_req(sacta_pkg::REQ_LOOKUP);
            if ($urandom_range(0, 4) == 0) r.req_type = 1'($urandom_range(0, 1));
            send_req(r);
            if (r.req_type == sacta_pkg::REQ_LOOKUP && $urandom_range(0, 3) != 0) begin
                r.req_type = sacta_pkg::REQ_INSTALL;
                send_req(r);
                k++;
            end
        end
    endtask

    function automatic sacta_pkg::t_req fixed_req(logic kind, logic [47:0] addr, logic wr,
                                                  logic [1:0] core, logic [47:0] ts);
        sacta_pkg::t_req r;
        r.req_type = kind;
        r.line_addr = addr;
        r.wr_req = wr;
        r.core_num = core;
        r.time_stamp = ts;
        return r;
    endfunction

    task automatic test_directed();
        send_req(fixed_req(sacta_pkg::REQ_LOOKUP, 48'h000000000105, 1'b0, 2'd0, 48'd1));
        send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'h000000000105, 1'b0, 2'd1, 48'd2));
        send_req(fixed_req(sacta_pkg::REQ_LOOKUP, 48'h000000000105, 1'b0, 2'd2, 48'd3));
        send_req(fixed_req(sacta_pkg::REQ_LOOKUP, 48'h000000000105, 1'b1, 2'd3, 48'd4));
        send_req(fixed_req(sacta_pkg::REQ_LOOKUP, 48'hFFFFFFFFFFFF, 1'b1, 2'd3, 48'd5));
        send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'hFFFFFFFFFFFF, 1'b1, 2'd3,
                           48'hFFFFFFFFFFFF));
        send_req(fixed_req(sacta_pkg::REQ_LOOKUP, 48'hFFFFFFFFFFFF, 1'b0, 2'd0, 48'd6));
        // A timestamp of zero has no older line, so way 0 is replaced.
        send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'h000000000205, 1'b0, 2'd2, 48'd0));
        send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'h000000000305, 1'b1, 2'd1, 48'd0));
        for (int k = 0; k < 6; k++)
            send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'(k + 4) << 8 | 48'h05, 1'(k),
                               2'(k), 48'd10 + 48'(k)));
        send_req(fixed_req(sacta_pkg::REQ_LOOKUP, 48'h000000000000, 1'b0, 2'd0, 48'd0));
        // Single way: each install of set 5 displaces the line before it, the second and third a dirty one.
        set_config(sacta_pkg::MODE_LRU, 5'd1, 5'd8);
        send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'h000000000A05, 1'b1, 2'd1, 48'd40));
        send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'h000000000B05, 1'b1, 2'd2, 48'd41));
        send_req(fixed_req(sacta_pkg::REQ_INSTALL, 48'h000000000C05, 1'b0, 2'd3, 48'd42));
    endtask

    task automatic test_lru();
        set_config(sacta_pkg::MODE_LRU, 5'd4, 5'd2);
        run_traffic(120);
        set_config(sacta_pkg::MODE_LRU, 5'd16, 5'd8);
        run_traffic(100);
        set_config(sacta_pkg::MODE_LRU, 5'd2, 5'd0);
        run_traffic(80);
    endtask

    task automatic test_random_mode();
        set_config(sacta_pkg::MODE_RANDOM, 5'd16, 5'd3);
        run_traffic(120);
        set_config(sacta_pkg::MODE_RANDOM, 5'd3, 5'd1);
        run_traffic(80);
    endtask

    task automatic test_out_of_range_config();
        // Zero ways act as one; oversized counts and set bits saturate.
        set_config(sacta_pkg::MODE_LRU, 5'd0, 5'd15);
        run_traffic(50);
        set_config(sacta_pkg::MODE_RANDOM, 5'd31, 5'd9);
        run_traffic(60);
        set_config(sacta_pkg::MODE_LRU, 5'd17, 5'd4);
        wait_idle();
        write_reg(2'd3, 5'd31);
        run_traffic(40);
    endtask

    task automatic test_back_to_back();
        set_config(sacta_pkg::MODE_LRU, 5'd8, 5'd2);
        idle_on = 1'b0;
        run_traffic(100);
        idle_on = 1'b1;
    endtask

    task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Response side: check each accepted response and stall ready at random.
    int rsp_stall = 0;
    always @(posedge i_clk) begin
        sacta_pkg::t_rsp e;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (o_rsp_valid && i_rsp_ready) begin
            n_rsps++;
            if (pending_rsp.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
            end else begin
                e = pending_rsp.pop_front();
                if (e.hit) n_hits++;
                if (e.victim_dirty) n_dirty_victims++;
                cmp_field("hit", e.hit, o_rsp.hit);
                cmp_field("victim_valid", e.victim_valid, o_rsp.victim_valid);
                cmp_field("victim_dirty", e.victim_dirty, o_rsp.victim_dirty);
                cmp_field("victim_line_addr", e.victim_line_addr, o_rsp.victim_line_addr);
                cmp_field("victim_core", e.victim_core, o_rsp.victim_core);
                cmp_field("read_accesses", e.read_accesses, o_rsp.read_accesses);
                cmp_field("write_accesses", e.write_accesses, o_rsp.write_accesses);
                cmp_field("read_misses", e.read_misses, o_rsp.read_misses);
                cmp_field("write_misses", e.write_misses, o_rsp.write_misses);
                cmp_field("dirty_evictions", e.dirty_evictions, o_rsp.dirty_evictions);
            end
            rsp_stall = idle_on ? $urandom_range(0, 16) : 0;
            i_rsp_ready <= (rsp_stall == 0);
        end else if (rsp_stall > 0) begin
            rsp_stall--;
            i_rsp_ready <= (rsp_stall == 0);
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < sacta_pkg::SETS; s++)
            for (int w = 0; w < sacta_pkg::WAYS; w++)
                cache_lines[s][w] = '0;
        lfsr_state = sacta_pkg::LFSR_SEED;
        {cnt_rd, cnt_wr, cnt_rd_miss, cnt_wr_miss, cnt_dirty_ev} = '0;
        mode_reg = sacta_pkg::MODE_LRU;
        ways_reg = 5'd16;
        setb_reg = 4'd8;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_lru();
        test_random_mode();
        test_out_of_range_config();
        test_back_to_back();
        wait_idle();
        $display("Sent %0d requests, checked %0d responses: %0d hits, %0d dirty victims,",
                 n_reqs, n_rsps, n_hits, n_dirty_victims);
        $display("over LRU and random replacement with in-range and saturated settings.");
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
